// File: rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// shared types, register indexes and digit weights for the torque frame parser
// ----------------------------------------------------------------------------
package tfp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned ValueWidth  = 16;
   localparam int unsigned WeightWidth = 14;
   localparam int unsigned CsrIdxWidth = 1;

   localparam logic [ByteWidth-1:0]  AsciiZero        = 8'd48;
   localparam logic [ByteWidth-1:0]  StartCharReset   = 8'd43;
   localparam logic [ValueWidth-1:0] RejectLimitReset = 16'd25000;

   localparam logic [CsrIdxWidth-1:0] CsrStartChar   = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CsrRejectLimit = 1'd1;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_SKIP = 3'd1,
      PH_D0   = 3'd2,
      PH_D1   = 3'd3,
      PH_D2   = 3'd4,
      PH_D3   = 3'd5,
      PH_SEP  = 3'd6,
      PH_D4   = 3'd7
   } phase_type;

   typedef struct packed {
      logic                  frame_end;
      logic [ValueWidth-1:0] value;
      logic                  held;
   } result_type;

   function automatic logic [WeightWidth-1:0] digit_weight(input phase_type ph);
      logic [WeightWidth-1:0] w;
      case (ph)
         PH_D0:   w = 14'd10000;
         PH_D1:   w = 14'd1000;
         PH_D2:   w = 14'd100;
         PH_D3:   w = 14'd10;
         PH_D4:   w = 14'd1;
         default: w = 14'd0;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/tfp_parse.sv
// ----------------------------------------------------------------------------
// tfp_parse
// frame sequencer, digit accumulator and rejection against the last good value
// ----------------------------------------------------------------------------
module tfp_parse import tfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [ByteWidth-1:0]  rx_byte,
   input  logic [ByteWidth-1:0]  start_char,
   input  logic [ValueWidth-1:0] reject_limit,
   output result_type            result
);

   localparam int unsigned ProdWidth = ByteWidth + WeightWidth;

   phase_type               phase_ff, phase_in;
   logic [ValueWidth-1:0]   accum_ff, accum_in;
   logic [ValueWidth-1:0]   last_good_ff, last_good_in;
   logic [ByteWidth-1:0]    digit;
   logic [ProdWidth-1:0]    product;
   logic [ValueWidth-1:0]   base;
   logic [ValueWidth-1:0]   sum;
   logic                    is_digit;
   logic                    rejected;

   // next phase
   always_comb begin
      case (phase_ff)
         PH_HUNT: phase_in = (rx_byte == start_char) ? PH_SKIP : PH_HUNT;
         PH_SKIP: phase_in = PH_D0;
         PH_D0:   phase_in = PH_D1;
         PH_D1:   phase_in = PH_D2;
         PH_D2:   phase_in = PH_D3;
         PH_D3:   phase_in = PH_SEP;
         PH_SEP:  phase_in = PH_D4;
         PH_D4:   phase_in = PH_HUNT;
         default: phase_in = PH_HUNT;
      endcase
   end

   // digit datapath and outputs
   always_comb begin
      is_digit = phase_ff inside {PH_D0, PH_D1, PH_D2, PH_D3, PH_D4};
      digit    = rx_byte - AsciiZero;
      product  = ProdWidth'(digit) * ProdWidth'(digit_weight(phase_ff));
      base     = (phase_ff == PH_D0) ? '0 : accum_ff;
      sum      = base + product[ValueWidth-1:0];
      rejected = sum >= reject_limit;

      accum_in         = is_digit ? sum : accum_ff;
      result.frame_end = (phase_ff == PH_D4);
      result.held      = rejected;
      result.value     = rejected ? last_good_ff : sum;
      last_good_in     = result.frame_end ? result.value : last_good_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         accum_ff     <= '0;
         last_good_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         last_good_ff <= last_good_in;
      end
   end

endmodule

// File: rtl/torque_frame_parser.sv
// ----------------------------------------------------------------------------
// torque_frame_parser
// parses serial frames from a torque indicator into readings in tenths
// ----------------------------------------------------------------------------
// One received byte enters per req beat and the block takes one byte every
// cycle while intake is not stopped: a byte sits in the input register, where
// the frame sequencer consumes it combinationally (one 8 x 14 bit multiply-add
// and a compare). Bytes are dropped until start_char; after it one byte is
// skipped, four digits are taken, a separator is skipped and a fifth digit
// closes the frame and sets the rsp register, raising rsp_tvalid:
// tdata is the reading in tenths and tuser is set when the reading reached
// reject_limit and the previous good reading was repeated. Only a stalled rsp
// holding a finished reading can stop intake. Write csr registers only while
// no frame byte is in flight.
module torque_frame_parser import tfp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ByteWidth-1:0]   req_tdata,    // [7:0] rx_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ValueWidth-1:0]  rsp_tdata,    // [15:0] torque_tenths
   output logic                   rsp_tuser,    // [0] held
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ValueWidth-1:0]  csr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff, in_byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_held_ff, rsp_held_in;
   logic [ByteWidth-1:0]  start_char_ff;
   logic [ValueWidth-1:0] reject_limit_ff;
   logic                  req_accept;
   logic                  out_free;
   logic                  adv;
   result_type            result;

   tfp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (adv),
      .rx_byte      (in_byte_ff),
      .start_char   (start_char_ff),
      .reject_limit (reject_limit_ff),
      .result       (result)
   );

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      adv         = in_valid_ff && (!result.frame_end || out_free);
      req_tready  = !in_valid_ff || adv;
      req_accept  = req_tvalid && req_tready;
      in_valid_in = req_accept || (in_valid_ff && !adv);
      in_byte_in  = req_accept ? req_tdata : in_byte_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_held_in  = rsp_held_ff;
      if (adv && result.frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result.value;
         rsp_held_in  = result.held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      rsp_value_ff <= rsp_value_in;
      rsp_held_ff  <= rsp_held_in;
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff   <= StartCharReset;
         reject_limit_ff <= RejectLimitReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrStartChar:   start_char_ff   <= csr_data[ByteWidth-1:0];
            CsrRejectLimit: reject_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_held_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (adv && result.frame_end) |-> (!rsp_valid_ff || rsp_tready))
      else $error("finished reading overwrote a pending rsp beat");

   a_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a byte");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for torque_frame_parser: a short table of hand-built
// frames, then random frames with noise under several register settings and
// idle/stall mixes; every rsp beat is checked against the table or a bench decoder
// ----------------------------------------------------------------------------
module testbench;
   import tfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ValueWidth-1:0] tenths;
      logic                  held;
   } reading_type;

   typedef struct {
      logic [ByteWidth-1:0]  rx;
      bit                    typed;
      logic [ValueWidth-1:0] tenths;
      logic                  held;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ByteWidth-1:0]   req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [ValueWidth-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [ValueWidth-1:0]  csr_data;

   // decoder state and its copy of the registers
   phase_type             frame_phase;
   logic [ValueWidth-1:0] frame_sum;
   logic [ValueWidth-1:0] good_reading;
   logic [ByteWidth-1:0]  start_byte;
   logic [ValueWidth-1:0] reject_lim;

   reading_type pending_readings[$];
   int unsigned mismatches;
   int unsigned send_idle;
   int unsigned rsp_stall;

   row_type opening_rows [25] = '{
      '{8'h00,          0, 16'd0,     1'b0},
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{" ",            0, 16'd0,     1'b0},
      '{"2",            0, 16'd0,     1'b0},
      '{"4",            0, 16'd0,     1'b0},
      '{"9",            0, 16'd0,     1'b0},
      '{"9",            0, 16'd0,     1'b0},
      '{".",            0, 16'd0,     1'b0},
      '{"9",            1, 16'd24999, 1'b0},
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{8'hff,          0, 16'd0,     1'b0},
      '{"2",            0, 16'd0,     1'b0},
      '{"5",            0, 16'd0,     1'b0},
      '{"0",            0, 16'd0,     1'b0},
      '{"0",            0, 16'd0,     1'b0},
      '{8'h00,          0, 16'd0,     1'b0},
      '{"0",            1, 16'd24999, 1'b1},
      // start char in skip, digit and separator slots, non-digit bytes as digits
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{8'hff,          0, 16'd0,     1'b0},
      '{"/",            0, 16'd0,     1'b0},
      '{":",            0, 16'd0,     1'b0},
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{StartCharReset, 0, 16'd0,     1'b0},
      '{8'hff,          0, 16'd0,     1'b0}
   };

   torque_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall);
   end

   function automatic void decode_byte(input logic [ByteWidth-1:0] rx, output bit made,
                                       output reading_type reading);
      logic [ByteWidth-1:0]  digit;
      logic [ValueWidth-1:0] weight;
      logic [ValueWidth-1:0] sum;
      digit = rx - AsciiZero;
      case (frame_phase)
         PH_D0:   weight = 16'd10000;
         PH_D1:   weight = 16'd1000;
         PH_D2:   weight = 16'd100;
         PH_D3:   weight = 16'd10;
         PH_D4:   weight = 16'd1;
         default: weight = 16'd0;
      endcase
      sum = (frame_phase == PH_D0) ? 16'd0 : frame_sum;
      sum = sum + 16'(32'(digit) * 32'(weight));
      frame_sum = sum;
      made = 1'b0;
      reading = '{16'd0, 1'b0};
      case (frame_phase)
         PH_HUNT: begin
            if (rx == start_byte) frame_phase = PH_SKIP;
         end
         PH_D4: begin
            reading.held = (sum >= reject_lim);
            reading.tenths = reading.held ? good_reading : sum;
            good_reading = reading.tenths;
            made = 1'b1;
            frame_phase = PH_HUNT;
         end
         default: begin
            frame_phase = phase_type'(frame_phase + 3'd1);
         end
      endcase
   endfunction

   task automatic send_byte(input logic [ByteWidth-1:0] rx, input bit typed = 1'b0,
                            input logic [ValueWidth-1:0] typed_tenths = '0,
                            input logic typed_held = 1'b0);
      reading_type got;
      bit made;
      while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rx;
      do @(posedge clock); while (!req_tready);
      decode_byte(rx, made, got);
      if (made) begin
         if (typed) pending_readings.push_back('{typed_tenths, typed_held});
         else pending_readings.push_back(got);
      end
   endtask

   task automatic send_frame();
      logic [ByteWidth-1:0]  frame [8];
      logic [ValueWidth-1:0] target;
      int unsigned dig [5];
      bit aim;
      int k;
      aim = ($urandom_range(0, 9) == 0);
      // aimed frames land on the limit or just below it
      target = reject_lim - 16'($urandom_range(0, 1));
      dig[0] = target / 10000;
      dig[1] = (target / 1000) % 10;
      dig[2] = (target / 100) % 10;
      dig[3] = (target / 10) % 10;
      dig[4] = target % 10;
      frame[0] = start_byte;
      frame[1] = 8'($urandom);
      frame[6] = 8'($urandom);
      for (k = 0; k < 5; k++) begin
         if (!aim) dig[k] = $urandom_range(0, 9);
         frame[(k < 4) ? k + 2 : 7] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                  : AsciiZero + 8'(dig[k]);
      end
      for (k = 0; k < 8; k++) send_byte(frame[k]);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [ValueWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrStartChar:   start_byte = value[ByteWidth-1:0];
         CsrRejectLimit: reject_lim = value;
         default: ;
      endcase
   endtask

   task automatic settle();
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected rsp beat: torque_tenths %0d held %0d", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata !== want.tenths) begin
               $error("torque_tenths: expected %0d, actual %0d", want.tenths, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.held) begin
               $error("held: expected %0d, actual %0d", want.held, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int i;
      int p;
      int unsigned sent;
      logic [ByteWidth-1:0]  sc;
      logic [ValueWidth-1:0] lim;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      send_idle = 0;
      rsp_stall = 0;
      frame_phase = PH_HUNT;
      frame_sum = '0;
      good_reading = '0;
      start_byte = StartCharReset;
      reject_lim = RejectLimitReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         send_byte(opening_rows[i].rx, opening_rows[i].typed, opening_rows[i].tenths,
                   opening_rows[i].held);
      end
      req_tvalid <= 1'b0;
      settle();

      for (p = 0; p < 8; p++) begin
         case (p)
            0: begin
               sc = 8'd0;
               lim = 16'd0;
            end
            1: begin
               sc = 8'd255;
               lim = 16'hffff;
            end
            2: begin
               sc = StartCharReset;
               lim = 16'd1;
            end
            default: begin
               sc = 8'($urandom);
               lim = 16'($urandom);
            end
         endcase
         write_csr(CsrStartChar, {8'($urandom), sc});
         write_csr(CsrRejectLimit, lim);
         csr_valid <= 1'b0;
         case (p % 4)
            0: begin
               send_idle = 0;
               rsp_stall = 0;
            end
            1: begin
               send_idle = 84;
               rsp_stall = 0;
            end
            2: begin
               send_idle = 0;
               rsp_stall = 84;
            end
            default: begin
               send_idle = 34;
               rsp_stall = 34;
            end
         endcase
         sent = 0;
         while (sent < 132) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
               send_frame();
               sent += 8;
            end
         end
         req_tvalid <= 1'b0;
         settle();
      end

      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
